// ----- rtl/otpsec_pkg.sv -----
`default_nettype none

package otpsec_pkg;

  // Operation select
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CODE_W = 22;
  localparam int unsigned ROW_W  = 24;
  localparam int unsigned PAR_N  = 6;

  // Polarity field codes (row bits 23:22)
  localparam logic [1:0] POL_NONE = 2'b00;
  localparam logic [1:0] POL_BOTH = 2'b11;

  localparam logic [ROW_W-1:0] POL_HI = 24'h80_0000;
  localparam logic [ROW_W-1:0] POL_LO = 24'h40_0000;

  // Parity coverage masks; bit i of the row is covered when set
  localparam logic [CODE_W-1:0] PAR_MASK [PAR_N] = '{
    22'b0000001010110101011011,
    22'b0000000011011001101101,
    22'b0000001100011110001110,
    22'b0000000000011111110000,
    22'b0000001111100000000000,
    22'b0111111111111111111111
  };

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BOTH_POL  = 3'd1,
    ST_NO_POL    = 3'd2,
    ST_SYN_POL   = 3'd3,
    ST_PERFECT   = 3'd4,
    ST_MULTI     = 3'd5,
    ST_BAD_SYN   = 3'd6,
    ST_FLIPS     = 3'd7
  } status_e;

  typedef struct packed {
    logic [CODE_W-1:0] word;
    status_e           status;
  } result_t;

  // Build the 22-bit code row; only the last parity bit also covers the other parity bits
  function automatic logic [CODE_W-1:0] enc_row(input logic [DATA_W-1:0] data);
    logic [CODE_W-1:0] row;
    row = {{(CODE_W-DATA_W){1'b0}}, data};
    for (int i = 0; i < PAR_N; i++) begin
      row[DATA_W+i] = ^(row & PAR_MASK[i]);
    end
    return row;
  endfunction

  // Syndrome to data-bit flip mask; zero where no data bit is named
  function automatic logic [DATA_W-1:0] syn_flip(input logic [4:0] syn);
    logic [DATA_W-1:0] flip;
    case (syn)
      5'd3:    flip = 16'h0001;
      5'd5:    flip = 16'h0002;
      5'd6:    flip = 16'h0004;
      5'd7:    flip = 16'h0008;
      5'd9:    flip = 16'h0010;
      5'd10:   flip = 16'h0020;
      5'd11:   flip = 16'h0040;
      5'd12:   flip = 16'h0080;
      5'd13:   flip = 16'h0100;
      5'd14:   flip = 16'h0200;
      5'd15:   flip = 16'h0400;
      5'd17:   flip = 16'h0800;
      5'd18:   flip = 16'h1000;
      5'd19:   flip = 16'h2000;
      5'd20:   flip = 16'h4000;
      5'd21:   flip = 16'h8000;
      default: flip = '0;
    endcase
    return flip;
  endfunction

  // True when at most one bit is set
  function automatic logic le_one_bit(input logic [ROW_W-1:0] v);
    return ((v & (v - 1'b1)) == '0);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/otpsec_datapath.sv -----
`default_nettype none

module otpsec_datapath (
  input  logic                                func_i,
  input  logic [otpsec_pkg::ROW_W-1:0]        word_i,
  output otpsec_pkg::result_t                 result_o
);
  import otpsec_pkg::*;

  logic [1:0]        pol;
  logic              pol_single;
  logic [CODE_W-1:0] enc_a, enc_b;
  logic [ROW_W-1:0]  diff_a, diff_b;
  logic              match_a, match_b;
  logic [ROW_W-1:0]  src;
  logic [CODE_W-1:0] calc, diff;
  logic [4:0]        syn;
  logic              msb;
  logic [DATA_W-1:0] flip;
  logic [DATA_W-1:0] data;
  status_e           core_st;
  logic [CODE_W-1:0] chk;
  logic [ROW_W-1:0]  chk_diff, inv_diff;
  logic              chk_ok;

  assign pol        = word_i[23:22];
  assign pol_single = (pol != POL_NONE) && (pol != POL_BOTH);

  // Single polarity bit: try the row as stored and as inverted
  assign enc_a   = enc_row(word_i[DATA_W-1:0]);
  assign enc_b   = enc_row(~word_i[DATA_W-1:0]);
  assign diff_a  = word_i ^ {2'b00, enc_a};
  assign diff_b  = word_i ^ {2'b11, ~enc_b};
  assign match_a = (diff_a == POL_HI) || (diff_a == POL_LO);
  assign match_b = (diff_b == POL_HI) || (diff_b == POL_LO);

  // Normal path: un-invert when both polarity bits set, then syndrome
  assign src  = (pol == POL_BOTH) ? ~word_i : word_i;
  assign calc = enc_row(src[DATA_W-1:0]);
  assign diff = calc ^ src[CODE_W-1:0];
  assign syn  = diff[20:16];
  assign msb  = diff[21] ^ (^syn);
  assign flip = syn_flip(syn);

  // Decode status and candidate data
  always_comb begin
    data    = src[DATA_W-1:0];
    core_st = ST_OK;
    if (pol_single) begin
      if (match_a && match_b) begin
        core_st = ST_BOTH_POL;
      end else if (match_a) begin
        data = word_i[DATA_W-1:0];
      end else if (match_b) begin
        data = ~word_i[DATA_W-1:0];
      end else begin
        core_st = ST_NO_POL;
      end
    end else if (le_one_bit({2'b00, diff})) begin
      // clean row, or a single flip in the parity bits
      data = src[DATA_W-1:0];
    end else if (syn == 5'd1) begin
      core_st = ST_SYN_POL;
    end else if (!msb && (syn == '0)) begin
      core_st = ST_PERFECT;
    end else if (!msb) begin
      core_st = ST_MULTI;
    end else if (flip == '0) begin
      core_st = ST_BAD_SYN;
    end else begin
      data = src[DATA_W-1:0] ^ flip;
    end
  end

  // Final distance check of the answer against the raw row
  assign chk      = enc_row(data);
  assign chk_diff = word_i ^ {2'b00, chk};
  assign inv_diff = word_i ^ {2'b11, ~chk};
  assign chk_ok   = (le_one_bit(chk_diff) && (pol != POL_BOTH)) ||
                    (le_one_bit(inv_diff) && (pol != POL_NONE));

  // Result select
  always_comb begin
    if (func_i == FUNC_ENCODE) begin
      result_o.word   = enc_a;
      result_o.status = ST_OK;
    end else if (core_st != ST_OK) begin
      result_o.word   = '0;
      result_o.status = core_st;
    end else if (!chk_ok) begin
      result_o.word   = '0;
      result_o.status = ST_FLIPS;
    end else begin
      result_o.word   = {{(CODE_W-DATA_W){1'b0}}, data};
      result_o.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/otp_row_secded_codec_top.sv -----
// OTP row SECDED(22,16) codec with polarity repair.
//
// Input channel (in_valid_i / in_ready_o) carries func_i and word_in_i:
// func_i = 0 encodes word_in_i[15:0] into a 22-bit row, func_i = 1 decodes
// a raw 24-bit row (polarity bits 23:22) into 16 data bits plus a status.
// Output channel (out_valid_o / out_ready_i) carries word_out_o and
// status_o; word_out_o is zero whenever status_o is nonzero.
//
// The result passes through the input register, then the result register,
// before it is offered on the output channel. Throughput: one item per
// cycle while out_ready_i is high, bounded by the single-pass parity/syndrome
// logic between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; in_ready_o drops only when both are
// full and out_ready_i is low.
// Reset (rst_ni low) empties both registers; no item is in flight after it.
`default_nettype none

module otp_row_secded_codec_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [23:0] word_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] word_out_o,
  output logic [2:0]  status_o
);
  import otpsec_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic              func_q;
  logic [ROW_W-1:0]  word_q;
  logic              out_valid_q, out_valid_d;
  result_t           res_d, res_q;
  logic              s1_ready, s2_ready;

  // Pipeline handshake
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !in_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    in_valid_d  = s1_ready ? in_valid_i : in_valid_q;
    out_valid_d = s2_ready ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      func_q <= func_i;
      word_q <= word_in_i;
    end
  end

  otpsec_datapath u_datapath (
    .func_i   (func_q),
    .word_i   (word_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_valid_q && s2_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = res_q.word;
  assign status_o    = res_q.status;

endmodule

`default_nettype wire

// ----- rtl/otpsec_checker.sv -----
`default_nettype none

module otpsec_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [21:0] word_out_o,
  input  logic [2:0]  status_o
);
  import otpsec_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(word_out_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Any error status comes with a zeroed word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (word_out_o == '0))
    else $error("nonzero word with error status");

  // Input backpressure only when the output side is full and stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // A transfer into an empty output side must later show up as a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("result missing after transfer");

endmodule

bind otp_row_secded_codec_top otpsec_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .word_out_o  (word_out_o),
  .status_o    (status_o)
);

`default_nettype wire
